// File: rtl/ssmd_pkg.sv
package ssmd_pkg;

    localparam int NUM_SYMBOLS = 21;

    localparam logic [4:0]  BLANK_CODE   = 5'd20;
    localparam logic [15:0] SCALED_LIMIT = 16'h0550;
    localparam logic [7:0]  PORT_B_BITS  = 8'h30;
    localparam logic [7:0]  PORT_C_BITS  = 8'h90;
    localparam logic [7:0]  PORT_D_BITS  = 8'h0E;
    localparam logic [7:0]  POINT_BIT    = 8'h08;

    localparam logic [1:0] DOT_POSITION_RESET = 2'd1;

    localparam logic [2:0] FUNC_FOUR   = 3'd0;
    localparam logic [2:0] FUNC_UPPER  = 3'd1;
    localparam logic [2:0] FUNC_LOWER  = 3'd2;
    localparam logic [2:0] FUNC_SCALED = 3'd3;
    localparam logic [2:0] FUNC_SCAN   = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] value;
        logic [1:0]  scan_digit;
        logic        dot_on;
    } in_word_t;

    typedef struct packed {
        logic [7:0] segments_b;
        logic [7:0] segments_c;
        logic [7:0] segments_d;
        logic [3:0] digit_enable;
    } out_word_t;

    localparam logic [7:0] SEG_B_TAB [32] = '{
        8'hCF, 8'hFF, 8'hCF, 8'hEF, 8'hFF, 8'hEF, 8'hCF, 8'hFF,
        8'hCF, 8'hEF, 8'hCF, 8'hFF, 8'hDF, 8'h6F, 8'hDF, 8'hDF,
        8'hFF, 8'hDF, 8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

    localparam logic [7:0] SEG_C_TAB [32] = '{
        8'hEF, 8'hEF, 8'h7F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'hEF,
        8'h6F, 8'h6F, 8'h6F, 8'h2F, 8'h3F, 8'h2F, 8'h3F, 8'h7F,
        8'hFF, 8'hBF, 8'hAF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

    localparam logic [7:0] SEG_D_TAB [32] = '{
        8'hF1, 8'hFD, 8'hF5, 8'hF5, 8'hF9, 8'hF3, 8'hF3, 8'hF5,
        8'hF1, 8'hF1, 8'hF7, 8'hF7, 8'hFF, 8'hF7, 8'hF7, 8'hF7,
        8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

    // reciprocal multiplies, exact for x <= 9999
    function automatic logic [9:0] div10(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd6554;
        return p[25:16];
    endfunction

    function automatic logic [6:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd5243;
        return p[25:19];
    endfunction

    function automatic logic [3:0] div1000(input logic [13:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'd8389;
        return p[26:23];
    endfunction

endpackage

// File: rtl/seven_segment_mux_display_core.sv
// A scan tick accepted on in is held in the input stage, then its word is registered into out_data.
// Throughput: one word per cycle on in; write operations produce no output word.
// in_ready drops only while a scan tick waits behind an output word not yet taken.
// Reset (rst_n low, asynchronous): digit buffer cleared to code 0, dot_position set
// to 1, input and output stages emptied.
module seven_segment_mux_display_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssmd_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssmd_pkg::out_word_t  out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata
);
    import ssmd_pkg::*;

    logic        s1_valid_reg;
    in_word_t    s1_data_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;
    out_word_t   out_data_next;
    logic [1:0]  dot_position_reg;
    logic [4:0]  digit_buffer_reg [4];

    logic        s1_is_scan;
    logic        s1_fire;
    logic        out_load;

    logic [13:0] sat_value;
    logic [14:0] scaled_prod;
    logic [13:0] bcd_in;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [6:0]  hu_wide;
    logic [9:0]  te_wide;
    logic [13:0] on_wide;
    logic [3:0]  th;
    logic [3:0]  hu;
    logic [3:0]  te;
    logic [3:0]  on;
    logic [4:0]  code_raw;
    logic [4:0]  code;

    assign s1_is_scan = (s1_data_reg.func == FUNC_SCAN);
    assign out_load   = s1_valid_reg && s1_is_scan && (!out_valid_reg || out_ready);
    assign s1_fire    = s1_valid_reg && (!s1_is_scan || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_fire;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // pick the number to split into decimal digits
    always_comb
    begin
        scaled_prod = 15'(s1_data_reg.value[10:0]) * 15'd10;
        sat_value   = s1_data_reg.value[13:0];
        case (s1_data_reg.func)
            FUNC_FOUR:
            begin
                if (s1_data_reg.value > 16'd9999)
                    sat_value = 14'd9999;
            end
            FUNC_UPPER, FUNC_LOWER:
            begin
                if (s1_data_reg.value > 16'd99)
                    sat_value = 14'd99;
            end
            default:
            begin
                sat_value = s1_data_reg.value[13:0];
            end
        endcase
        if (s1_data_reg.func == FUNC_SCALED)
            bcd_in = {3'b000, scaled_prod[14:4]};
        else
            bcd_in = sat_value;
    end

    always_comb
    begin
        q10     = div10(bcd_in);
        q100    = div100(bcd_in);
        q1000   = div1000(bcd_in);
        hu_wide = q100 - 7'(q1000) * 7'd10;
        te_wide = q10 - 10'(q100) * 10'd10;
        on_wide = bcd_in - 14'(q10) * 14'd10;
        th      = q1000;
        hu      = hu_wide[3:0];
        te      = te_wide[3:0];
        on      = on_wide[3:0];
    end

    // segment lookup for a scan tick
    always_comb
    begin
        code_raw = digit_buffer_reg[s1_data_reg.scan_digit];
        if ({1'b0, code_raw} >= 6'(NUM_SYMBOLS))
            code = BLANK_CODE;
        else
            code = code_raw;
        out_data_next.segments_b = PORT_B_BITS & SEG_B_TAB[code];
        out_data_next.segments_c = PORT_C_BITS & SEG_C_TAB[code];
        if (!(dot_position_reg == s1_data_reg.scan_digit && s1_data_reg.dot_on))
            out_data_next.segments_c = out_data_next.segments_c | POINT_BIT;
        out_data_next.segments_d   = PORT_D_BITS & SEG_D_TAB[code];
        out_data_next.digit_enable = 4'b0001 << s1_data_reg.scan_digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (out_load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dot_position_reg <= DOT_POSITION_RESET;
        else if (cfg_we)
            dot_position_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                digit_buffer_reg[i] <= 5'd0;
        end
        else if (s1_fire)
        begin
            case (s1_data_reg.func)
                FUNC_FOUR:
                begin
                    digit_buffer_reg[0] <= (th == 4'd0) ? BLANK_CODE : {1'b0, th};
                    digit_buffer_reg[1] <= (th == 4'd0 && hu == 4'd0) ?
                                           BLANK_CODE : {1'b0, hu};
                    digit_buffer_reg[2] <= (th == 4'd0 && hu == 4'd0 && te == 4'd0) ?
                                           BLANK_CODE : {1'b0, te};
                    digit_buffer_reg[3] <= {1'b0, on};
                end
                FUNC_UPPER:
                begin
                    digit_buffer_reg[0] <= (te == 4'd0) ? BLANK_CODE : {1'b0, te};
                    digit_buffer_reg[1] <= (te == 4'd0 && on == 4'd0) ?
                                           BLANK_CODE : {1'b0, on};
                end
                FUNC_LOWER:
                begin
                    digit_buffer_reg[2] <= {1'b0, te};
                    digit_buffer_reg[3] <= {1'b0, on};
                end
                FUNC_SCALED:
                begin
                    if (s1_data_reg.value > SCALED_LIMIT)
                    begin
                        digit_buffer_reg[0] <= 5'd8;
                        digit_buffer_reg[1] <= 5'd7;
                        digit_buffer_reg[2] <= 5'd7;
                        digit_buffer_reg[3] <= 5'd8;
                    end
                    else
                    begin
                        digit_buffer_reg[0] <= 5'd0;
                        digit_buffer_reg[1] <= {1'b0, hu};
                        digit_buffer_reg[2] <= {1'b0, te};
                        digit_buffer_reg[3] <= {1'b0, on};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: rtl/ssmd_checker.sv
module ssmd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ssmd_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input ssmd_pkg::out_word_t out_data
);
    import ssmd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(out_data.digit_enable))
        else $error("digit enable not one-hot");

    a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.segments_b & ~PORT_B_BITS) == 8'h00)
                   && ((out_data.segments_c & ~(PORT_C_BITS | POINT_BIT)) == 8'h00)
                   && ((out_data.segments_d & ~PORT_D_BITS) == 8'h00))
        else $error("segment byte has bits outside its port mask");

    a_scan_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.func == FUNC_SCAN |=> ##1 out_valid)
        else $error("scan tick produced no output word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind seven_segment_mux_display_core ssmd_checker u_ssmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/sv/ssmd_result_checker.sv
`timescale 1ns / 1ps

module ssmd_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  ssmd_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  ssmd_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    output int                  mismatch_count,
    output int                  words_pending
);
    import ssmd_pkg::*;

    localparam int         SYMBOL_COUNT = 21;
    localparam logic [4:0] BLANK_SYM    = 5'd20;
    localparam int         FOUR_MAX     = 9999;
    localparam int         PAIR_MAX     = 99;
    localparam int         OVER_RANGE   = 16'h0550;
    localparam int         REPORT_MAX   = 10;

    // active-low masks per symbol code, one table per port
    localparam logic [7:0] PB_MASK [32] = '{
        8'hCF, 8'hFF, 8'hCF, 8'hEF, 8'hFF, 8'hEF, 8'hCF, 8'hFF,
        8'hCF, 8'hEF, 8'hCF, 8'hFF, 8'hDF, 8'h6F, 8'hDF, 8'hDF,
        8'hFF, 8'hDF, 8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    localparam logic [7:0] PC_MASK [32] = '{
        8'hEF, 8'hEF, 8'h7F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'hEF,
        8'h6F, 8'h6F, 8'h6F, 8'h2F, 8'h3F, 8'h2F, 8'h3F, 8'h7F,
        8'hFF, 8'hBF, 8'hAF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    localparam logic [7:0] PD_MASK [32] = '{
        8'hF1, 8'hFD, 8'hF5, 8'hF5, 8'hF9, 8'hF3, 8'hF3, 8'hF5,
        8'hF1, 8'hF1, 8'hF7, 8'hF7, 8'hFF, 8'hF7, 8'hF7, 8'hF7,
        8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

    logic [4:0] digit_codes [4];
    logic [1:0] dot_pos;
    out_word_t  expected_words [$];

    function automatic out_word_t scan_segments(input logic [4:0] code, input logic [1:0] pos,
                                                input logic dot, input logic [1:0] dpos);
        out_word_t  w;
        logic [4:0] c;
        c = (int'(code) >= SYMBOL_COUNT) ? BLANK_SYM : code;
        w.segments_b   = 8'h30 & PB_MASK[c];
        w.segments_c   = (8'h90 & PC_MASK[c]) | ((dpos == pos && dot) ? 8'h00 : 8'h08);
        w.segments_d   = 8'h0E & PD_MASK[c];
        w.digit_enable = 4'b0001 << pos;
        return w;
    endfunction

    function automatic void store_number(input in_word_t w);
        int v;
        int th;
        int hu;
        int te;
        int on;
        v = int'(w.value);
        case (w.func)
            FUNC_FOUR:
            begin
                if (v > FOUR_MAX) v = FOUR_MAX;
                th = v / 1000;
                hu = (v / 100) % 10;
                te = (v / 10) % 10;
                on = v % 10;
                digit_codes[0] = (th == 0) ? BLANK_SYM : 5'(th);
                digit_codes[1] = (th == 0 && hu == 0) ? BLANK_SYM : 5'(hu);
                digit_codes[2] = (th == 0 && hu == 0 && te == 0) ? BLANK_SYM : 5'(te);
                digit_codes[3] = 5'(on);
            end
            FUNC_UPPER:
            begin
                if (v > PAIR_MAX) v = PAIR_MAX;
                te = v / 10;
                on = v % 10;
                digit_codes[0] = (te == 0) ? BLANK_SYM : 5'(te);
                digit_codes[1] = (te == 0 && on == 0) ? BLANK_SYM : 5'(on);
            end
            FUNC_LOWER:
            begin
                if (v > PAIR_MAX) v = PAIR_MAX;
                digit_codes[2] = 5'(v / 10);
                digit_codes[3] = 5'(v % 10);
            end
            FUNC_SCALED:
            begin
                if (v > OVER_RANGE)
                begin
                    digit_codes[0] = 5'd8;
                    digit_codes[1] = 5'd7;
                    digit_codes[2] = 5'd7;
                    digit_codes[3] = 5'd8;
                end
                else
                begin
                    v = (v * 10) >> 4;
                    digit_codes[0] = 5'd0;
                    digit_codes[1] = 5'(v / 100);
                    digit_codes[2] = 5'((v / 10) % 10);
                    digit_codes[3] = 5'(v % 10);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                digit_codes[k] = 5'd0;
            dot_pos = 2'd1;
            expected_words.delete();
            mismatch_count = 0;
            words_pending <= 0;
        end
        else
        begin
            // retire first so a word can never match an expectation pushed this edge
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected word: b=%h c=%h d=%h en=%b",
                                 out_data.segments_b, out_data.segments_c,
                                 out_data.segments_d, out_data.digit_enable);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.segments_b !== want.segments_b ||
                        out_data.segments_c !== want.segments_c ||
                        out_data.segments_d !== want.segments_d ||
                        out_data.digit_enable !== want.digit_enable)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch: exp b=%h c=%h d=%h en=%b, got b=%h c=%h d=%h en=%b",
                                     want.segments_b, want.segments_c,
                                     want.segments_d, want.digit_enable,
                                     out_data.segments_b, out_data.segments_c,
                                     out_data.segments_d, out_data.digit_enable);
                    end
                end
            end
            if (cfg_we)
                dot_pos = cfg_wdata;
            if (in_valid && in_ready)
            begin
                if (in_data.func == FUNC_SCAN)
                    expected_words.push_back(scan_segments(digit_codes[in_data.scan_digit],
                                                           in_data.scan_digit, in_data.dot_on,
                                                           dot_pos));
                else
                    store_number(in_data);
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

// File: tb/sv/tb_seven_segment_mux_display_core.sv
`timescale 1ns / 1ps

module tb_seven_segment_mux_display_core;
    import ssmd_pkg::*;

    localparam logic [2:0] FUNC_RSVD_TOP = 3'd7;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         PHASE_WORDS   = 120;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    in_word_t   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic       in_ready;
    logic       out_valid;
    out_word_t  out_data;

    int mismatch_count;
    int words_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    seven_segment_mux_display_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ssmd_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_word_t make_word(input logic [2:0] f, input logic [15:0] v,
                                           input logic [1:0] d, input logic dot);
        in_word_t w;
        w.func       = f;
        w.value      = v;
        w.scan_digit = d;
        w.dot_on     = dot;
        return w;
    endfunction

    // valid stays high between back-to-back words; lowered only for idle cycles
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic scan(input logic [1:0] d, input logic dot);
        send_word(make_word(FUNC_SCAN, 16'($urandom), d, dot));
    endtask

    task automatic write_num(input logic [2:0] f, input logic [15:0] v);
        send_word(make_word(f, v, 2'($urandom), 1'($urandom)));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
    endtask

    task automatic set_dot(input logic [1:0] p);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // weighted toward saturation and blanking edges
    function automatic logic [15:0] pick_value();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(0, 120));
            1:       return 16'($urandom_range(9990, 10010));
            2:       return 16'($urandom_range(16'h0540, 16'h0560));
            3:       return 16'($urandom_range(0, 9999));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        int done;
        int r;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                scan(2'($urandom), 1'($urandom));
                done++;
            end
            else if (r < 92)
            begin
                write_num(3'($urandom_range(FUNC_FOUR, FUNC_SCALED)), pick_value());
                done++;
            end
            else
            begin
                // reserved func codes, ignored by the block
                write_num(FUNC_SCAN + 3'($urandom_range(1, 3)), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared buffer, reset dot position
        scan(2'd0, 1'b1);
        scan(2'd1, 1'b1);
        scan(2'd2, 1'b1);
        scan(2'd3, 1'b0);
        // zero: all blank but the last digit
        write_num(FUNC_FOUR, 16'd0);
        scan(2'd0, 1'b0);
        scan(2'd1, 1'b1);
        scan(2'd2, 1'b0);
        scan(2'd3, 1'b1);
        write_num(FUNC_FOUR, 16'hFFFF);
        scan(2'd0, 1'b1);
        write_num(FUNC_UPPER, 16'd0);
        scan(2'd0, 1'b0);
        scan(2'd1, 1'b1);
        write_num(FUNC_UPPER, 16'hFFFF);
        scan(2'd0, 1'b0);
        write_num(FUNC_LOWER, 16'd5);
        scan(2'd2, 1'b1);
        write_num(FUNC_LOWER, 16'hFFFF);
        scan(2'd3, 1'b1);
        // just above and at the scaled-reading limit
        write_num(FUNC_SCALED, 16'h0551);
        scan(2'd0, 1'b1);
        write_num(FUNC_SCALED, 16'h0550);
        scan(2'd1, 1'b1);
        write_num(FUNC_RSVD_TOP, 16'd1234);
        scan(2'd3, 1'b0);

        set_dot(2'd0);
        random_phase(PHASE_WORDS);

        set_dot(2'd3);
        send_idle_pct = 53;
        random_phase(PHASE_WORDS);

        set_dot(2'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        random_phase(PHASE_WORDS);

        set_dot(2'd1);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        random_phase(PHASE_WORDS);

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/ssmd_pkg.sv
rtl/seven_segment_mux_display_core.sv
rtl/ssmd_checker.sv
tb/sv/ssmd_result_checker.sv
tb/sv/tb_seven_segment_mux_display_core.sv
